@@ src/clb_pkg.sv @@
// Shared types, widths and codes for the cluster light binning block.
// No dependencies; every other file but clb_ram imports this package.
`timescale 1ns / 1ps

package clb_pkg;

  localparam int MAX_POINT_LIGHTS = 16;
  localparam int MAX_SPOT_LIGHTS  = 16;
  localparam int OFFSET_BITS      = 20;

  localparam int FUNC_W        = 2;
  localparam int SLOT_W        = 4;
  localparam int COORD_W       = 32;
  localparam int RADIUS_W      = 31;
  localparam int LIST_OFFSET_W = 20;
  localparam int HITS_W        = 5;
  localparam int HIT_INDEX_W   = 4;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 5;

  localparam int P_AW  = (MAX_POINT_LIGHTS > 1) ? $clog2(MAX_POINT_LIGHTS) : 1;
  localparam int S_AW  = (MAX_SPOT_LIGHTS > 1) ? $clog2(MAX_SPOT_LIGHTS) : 1;
  localparam int IDX_W = (P_AW > S_AW) ? P_AW : S_AW;
  localparam int MAX_LIGHTS = (MAX_POINT_LIGHTS > MAX_SPOT_LIGHTS) ?
                              MAX_POINT_LIGHTS : MAX_SPOT_LIGHTS;
  localparam int CNT_W = $clog2(MAX_LIGHTS + 1);
  localparam int TOT_W = $clog2(MAX_POINT_LIGHTS + MAX_SPOT_LIGHTS + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_POINT  = 2'd0,
    FUNC_LOAD_SPOT   = 2'd1,
    FUNC_TEST_BOX    = 2'd2,
    FUNC_START_FRAME = 2'd3
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_POINT_LIGHT_COUNT = 1'b0,
    CFG_SPOT_LIGHT_COUNT  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [RADIUS_W-1:0]       r;
  } light_t;

  localparam int LIGHT_W = $bits(light_t);

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [SLOT_W-1:0]         light_slot;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [RADIUS_W-1:0]       radius;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
  } req_t;

  typedef struct packed {
    logic                     is_header;
    logic [LIST_OFFSET_W-1:0] list_offset;
    logic [HITS_W-1:0]        point_hits;
    logic [HITS_W-1:0]        spot_hits;
    logic [HIT_INDEX_W-1:0]   hit_index;
    logic                     hit_is_spot;
    logic                     last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic             load_point;
    logic             load_spot;
    logic             frame_start;
    logic             box_start;
    logic             issue;
    logic             issue_spot;
    logic [IDX_W-1:0] issue_idx;
    logic             show_header;
    logic             header_done;
    logic             entry_done;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CNT_W-1:0] np;
    logic [CNT_W-1:0] ns;
    logic             pipe_busy;
    logic             any_hits;
    logic             one_left;
  } dp_status_t;

endpackage

@@ src/clb_if.sv @@
// Valid/ready channel interfaces for the request and result streams.
// Depends on clb_pkg for field widths.
`timescale 1ns / 1ps

interface clb_req_if import clb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic [SLOT_W-1:0]         light_slot;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic [RADIUS_W-1:0]       radius;
  logic signed [COORD_W-1:0] box_max_x;
  logic signed [COORD_W-1:0] box_max_y;
  logic signed [COORD_W-1:0] box_max_z;

  modport source (output valid, func, light_slot, pos_x, pos_y, pos_z, radius,
                  box_max_x, box_max_y, box_max_z, input ready);
  modport sink (input valid, func, light_slot, pos_x, pos_y, pos_z, radius,
                box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface clb_resp_if import clb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     is_header;
  logic [LIST_OFFSET_W-1:0] list_offset;
  logic [HITS_W-1:0]        point_hits;
  logic [HITS_W-1:0]        spot_hits;
  logic [HIT_INDEX_W-1:0]   hit_index;
  logic                     hit_is_spot;
  logic                     last;

  modport source (output valid, is_header, list_offset, point_hits, spot_hits,
                  hit_index, hit_is_spot, last, input ready);
  modport sink (input valid, is_header, list_offset, point_hits, spot_hits,
                hit_index, hit_is_spot, last, output ready);
endinterface

@@ src/cluster_light_binning.sv @@
// Top level of the cluster light binning block: channel glue around the
// controller and datapath. Uses clb_pkg, clb_if, clb_controller, clb_datapath.
`timescale 1ns / 1ps

// Light loads (func 0/1) and frame start (func 3) give no result. A cluster
// box (func 2) is tested against np point and ns spot lights, where np and ns
// are the clamped point and spot counts: the light stores are read one light
// per cycle into a four-stage sphere/box test pipe, which then drains before
// the header. The header and then each hit entry go out as one result
// transfer each, and back-pressure on the result channel holds them. One item
// is worked at a time; the request channel is ready only between items. Light
// stores hold garbage until loaded.

module cluster_light_binning import clb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  clb_req_if.sink                req,
  clb_resp_if.source             resp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  req_t       req_data;
  res_t       res;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign req_data = '{
    func:       req.func,
    light_slot: req.light_slot,
    pos_x:      req.pos_x,
    pos_y:      req.pos_y,
    pos_z:      req.pos_z,
    radius:     req.radius,
    box_max_x:  req.box_max_x,
    box_max_y:  req.box_max_y,
    box_max_z:  req.box_max_z
  };

  clb_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_func   (req.func),
    .in_ready  (req.ready),
    .out_valid (resp.valid),
    .out_ready (resp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  clb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_data),
    .cmd       (cmd),
    .status    (status),
    .res       (res)
  );

  assign resp.is_header   = res.is_header;
  assign resp.list_offset = res.list_offset;
  assign resp.point_hits  = res.point_hits;
  assign resp.spot_hits   = res.spot_hits;
  assign resp.hit_index   = res.hit_index;
  assign resp.hit_is_spot = res.hit_is_spot;
  assign resp.last        = res.last;

endmodule

@@ src/clb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module clb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/clb_datapath.sv @@
// Datapath: light stores, count registers, four-stage sphere/box test pipe,
// hit masks, running offset and result formatting. Uses clb_pkg, clb_ram.
`timescale 1ns / 1ps

module clb_datapath import clb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  req_t                   req,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             status,
  output res_t                   res
);

  logic [CFG_DATA_W-1:0] np_cfg;
  logic [CFG_DATA_W-1:0] ns_cfg;

  logic signed [COORD_W-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

  logic [MAX_POINT_LIGHTS-1:0] pmask;
  logic [MAX_SPOT_LIGHTS-1:0]  smask;
  logic [OFFSET_BITS-1:0]      offset;

  // pipeline registers
  logic             v1, v2, v3, v4;
  logic             s1_spot, s2_spot, s3_spot, s4_spot;
  logic [IDX_W-1:0] s1_idx, s2_idx, s3_idx, s4_idx;
  logic [COORD_W-1:0]    s2_ax, s2_ay, s2_az;
  logic [RADIUS_W-1:0]   s2_r;
  logic [2*COORD_W-1:0]  s3_sx, s3_sy, s3_sz;
  logic [2*RADIUS_W-1:0] s3_r2;
  logic [2*COORD_W-1:0]  s4_sxy, s4_sz;
  logic [2*RADIUS_W-1:0] s4_r2;

  light_t point_rdata, spot_rdata, rec;
  light_t wr_light;

  logic p_we, s_we;

  function automatic logic [COORD_W-1:0] axis_dist(
    input logic signed [COORD_W-1:0] c,
    input logic signed [COORD_W-1:0] lo,
    input logic signed [COORD_W-1:0] hi
  );
    logic signed [COORD_W-1:0] v;
    logic signed [COORD_W:0]   d;
    v = (c < lo) ? lo : c;
    v = (v > hi) ? hi : v;
    d = {v[COORD_W-1], v} - {c[COORD_W-1], c};
    if (d < 0) begin
      d = -d;
    end
    return d[COORD_W-1:0];
  endfunction

  function automatic logic [2*COORD_W-1:0] sat_add(
    input logic [2*COORD_W-1:0] a,
    input logic [2*COORD_W-1:0] b
  );
    logic [2*COORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[2*COORD_W] ? {(2*COORD_W){1'b1}} : s[2*COORD_W-1:0];
  endfunction

  assign wr_light = '{x: req.pos_x, y: req.pos_y, z: req.pos_z, r: req.radius};
  assign p_we = cmd.load_point && (int'(req.light_slot) < MAX_POINT_LIGHTS);
  assign s_we = cmd.load_spot && (int'(req.light_slot) < MAX_SPOT_LIGHTS);

  clb_ram #(.WIDTH(LIGHT_W), .DEPTH(MAX_POINT_LIGHTS)) u_point_store (
    .clk   (clk),
    .we    (p_we),
    .waddr (P_AW'(req.light_slot)),
    .wdata (wr_light),
    .raddr (P_AW'(cmd.issue_idx)),
    .rdata (point_rdata)
  );

  clb_ram #(.WIDTH(LIGHT_W), .DEPTH(MAX_SPOT_LIGHTS)) u_spot_store (
    .clk   (clk),
    .we    (s_we),
    .waddr (S_AW'(req.light_slot)),
    .wdata (wr_light),
    .raddr (S_AW'(cmd.issue_idx)),
    .rdata (spot_rdata)
  );

  assign rec = s1_spot ? spot_rdata : point_rdata;

  logic [2*COORD_W-1:0] sq_dist;
  logic                 hit;
  assign sq_dist = sat_add(s4_sxy, s4_sz);
  assign hit     = sq_dist <= {2'b00, s4_r2};

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      np_cfg <= '0;
      ns_cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_POINT_LIGHT_COUNT: np_cfg <= cfg_data;
        CFG_SPOT_LIGHT_COUNT:  ns_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  // box bounds
  always_ff @(posedge clk) begin
    if (cmd.box_start) begin
      lo_x <= req.pos_x;
      lo_y <= req.pos_y;
      lo_z <= req.pos_z;
      hi_x <= req.box_max_x;
      hi_y <= req.box_max_y;
      hi_z <= req.box_max_z;
    end
  end

  // test pipeline valids and tags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s1_spot <= cmd.issue_spot;
    s1_idx  <= cmd.issue_idx;
    s2_spot <= s1_spot;
    s2_idx  <= s1_idx;
    s3_spot <= s2_spot;
    s3_idx  <= s2_idx;
    s4_spot <= s3_spot;
    s4_idx  <= s3_idx;
    // stage 1: clamp and absolute distance per axis
    s2_ax <= axis_dist(rec.x, lo_x, hi_x);
    s2_ay <= axis_dist(rec.y, lo_y, hi_y);
    s2_az <= axis_dist(rec.z, lo_z, hi_z);
    s2_r  <= rec.r;
    // stage 2: squares
    s3_sx <= s2_ax * s2_ax;
    s3_sy <= s2_ay * s2_ay;
    s3_sz <= s2_az * s2_az;
    s3_r2 <= s2_r * s2_r;
    // stage 3: first saturating add
    s4_sxy <= sat_add(s3_sx, s3_sy);
    s4_sz  <= s3_sz;
    s4_r2  <= s3_r2;
  end

  // entry selection: lowest set bit, point lights first
  logic [P_AW-1:0] p_low;
  logic [S_AW-1:0] s_low;
  logic            p_any, s_any;

  always_comb begin
    p_low = '0;
    for (int i = MAX_POINT_LIGHTS - 1; i >= 0; i--) begin
      if (pmask[i]) begin
        p_low = P_AW'(i);
      end
    end
    s_low = '0;
    for (int i = MAX_SPOT_LIGHTS - 1; i >= 0; i--) begin
      if (smask[i]) begin
        s_low = S_AW'(i);
      end
    end
  end

  assign p_any = |pmask;
  assign s_any = |smask;

  // hit masks
  always_ff @(posedge clk) begin
    if (cmd.box_start) begin
      pmask <= '0;
      smask <= '0;
    end else begin
      if (v4 && hit) begin
        if (s4_spot) begin
          smask[s4_idx[S_AW-1:0]] <= 1'b1;
        end else begin
          pmask[s4_idx[P_AW-1:0]] <= 1'b1;
        end
      end
      if (cmd.entry_done) begin
        if (p_any) begin
          pmask[p_low] <= 1'b0;
        end else begin
          smask[s_low] <= 1'b0;
        end
      end
    end
  end

  // running offset, saturating
  logic [TOT_W-1:0]       total;
  logic [OFFSET_BITS:0]   off_sum;
  localparam logic [OFFSET_BITS:0] OFF_MAX = {1'b0, {OFFSET_BITS{1'b1}}};

  assign total   = TOT_W'($countones(pmask)) + TOT_W'($countones(smask));
  assign off_sum = {1'b0, offset} + (OFFSET_BITS + 1)'(total);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cmd.frame_start) begin
      offset <= '0;
    end else if (cmd.header_done) begin
      offset <= (off_sum > OFF_MAX) ? OFF_MAX[OFFSET_BITS-1:0] :
                off_sum[OFFSET_BITS-1:0];
    end
  end

  // status
  always_comb begin
    status.np = (int'(np_cfg) > MAX_POINT_LIGHTS) ? CNT_W'(MAX_POINT_LIGHTS) :
                CNT_W'(np_cfg);
    status.ns = (int'(ns_cfg) > MAX_SPOT_LIGHTS) ? CNT_W'(MAX_SPOT_LIGHTS) :
                CNT_W'(ns_cfg);
    status.pipe_busy = v1 | v2 | v3 | v4;
    status.any_hits  = p_any | s_any;
    status.one_left  = $onehot({smask, pmask});
  end

  // result payload
  always_comb begin
    res = '0;
    if (cmd.show_header) begin
      res.is_header   = 1'b1;
      res.list_offset = LIST_OFFSET_W'(offset);
      res.point_hits  = HITS_W'($countones(pmask));
      res.spot_hits   = HITS_W'($countones(smask));
      res.last        = !(p_any | s_any);
    end else begin
      res.hit_is_spot = !p_any;
      res.hit_index   = p_any ? HIT_INDEX_W'(p_low) : HIT_INDEX_W'(s_low);
      res.last        = $onehot({smask, pmask});
    end
  end

endmodule

@@ src/clb_controller.sv @@
// Controller: sequences loads, frame starts, light tests, pipe drain, header and entries.
// Uses clb_pkg command and status structs.
`timescale 1ns / 1ps

module clb_controller import clb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dp_status_t        status,
  output ctrl_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POINT,
    S_SPOT,
    S_DRAIN,
    S_HEADER,
    S_ENTRY
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             in_xfer, out_xfer;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_HEADER) || (state == S_ENTRY);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  always_comb begin
    cmd = '0;
    cmd.issue_idx = IDX_W'(cnt);
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (func_t'(in_func))
            FUNC_LOAD_POINT:  cmd.load_point  = 1'b1;
            FUNC_LOAD_SPOT:   cmd.load_spot   = 1'b1;
            FUNC_TEST_BOX:    cmd.box_start   = 1'b1;
            FUNC_START_FRAME: cmd.frame_start = 1'b1;
            default: ;
          endcase
        end
      end
      S_POINT: begin
        cmd.issue = (cnt < status.np);
      end
      S_SPOT: begin
        cmd.issue      = (cnt < status.ns);
        cmd.issue_spot = 1'b1;
      end
      S_DRAIN: ;
      S_HEADER: begin
        cmd.show_header = 1'b1;
        cmd.header_done = out_xfer;
      end
      S_ENTRY: begin
        cmd.entry_done = out_xfer;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer && (func_t'(in_func) == FUNC_TEST_BOX)) begin
            state <= S_POINT;
            cnt   <= '0;
          end
        end
        S_POINT: begin
          if (cnt < status.np) begin
            cnt <= cnt + 1'b1;
          end else begin
            state <= S_SPOT;
            cnt   <= '0;
          end
        end
        S_SPOT: begin
          if (cnt < status.ns) begin
            cnt <= cnt + 1'b1;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!status.pipe_busy) begin
            state <= S_HEADER;
          end
        end
        S_HEADER: begin
          if (out_xfer) begin
            state <= status.any_hits ? S_ENTRY : S_IDLE;
          end
        end
        S_ENTRY: begin
          if (out_xfer && status.one_left) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
